@@ hdl/btfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER-TLV field extractor package
// Sizes, tag codes, the fixed field table and its lookup.
// ----------------------------------------------------------------------------
package btfe_pkg;

	localparam int NEST_LIMIT   = 30;
	localparam int RECORD_BYTES = 4096;
	localparam int TABLE_ROWS   = 15;

	localparam int OFF_W   = 13;
	localparam int LEN_W   = 16;
	localparam int GRP_W   = 16;
	localparam int ROW_W   = 4;
	localparam int BYTE_W  = 8;
	localparam int FRAME_DEPTH = NEST_LIMIT + 1;
	localparam int TOP_W   = $clog2(FRAME_DEPTH);
	localparam int SUM_W   = LEN_W + 1;

	localparam logic [BYTE_W-1:0] LEN_LONG1       = 8'h81;
	localparam logic [BYTE_W-1:0] LEN_LONG2       = 8'h82;
	localparam logic [BYTE_W-1:0] TAG_CONSTRUCTED = 8'h20;
	localparam logic [BYTE_W-1:0] CLASS_MASK      = 8'hC0;
	localparam logic [BYTE_W-1:0] CLASS_CTX       = 8'h80;

	typedef struct packed {
		logic [GRP_W-1:0]  group_id;
		logic [BYTE_W-1:0] tag;
		logic              is_date;
	} field_row_t;

	typedef struct packed {
		logic             hit;
		logic [ROW_W-1:0] row;
		logic             is_date;
	} field_match_t;

	localparam field_row_t FIELD_TABLE [TABLE_ROWS] = '{
		'{16'h0101, 8'h80, 1'b0}, '{16'h0101, 8'h81, 1'b0}, '{16'h0101, 8'h82, 1'b0},
		'{16'h0101, 8'h83, 1'b1}, '{16'h0101, 8'h84, 1'b0}, '{16'h0101, 8'h85, 1'b0},
		'{16'h0102, 8'h81, 1'b0},
		'{16'h0104, 8'h80, 1'b0}, '{16'h0104, 8'h81, 1'b1}, '{16'h0104, 8'h82, 1'b1},
		'{16'h0104, 8'h83, 1'b0},
		'{16'h0106, 8'h80, 1'b0},
		'{16'h0107, 8'h81, 1'b1}, '{16'h0107, 8'h82, 1'b1},
		'{16'h0109, 8'h80, 1'b0}
	};

	// first matching row wins: scan from the bottom so lower rows overwrite
	function automatic field_match_t lookup_field(input logic [GRP_W-1:0] grp,
			input logic [BYTE_W-1:0] tag);
		field_match_t m;
		m = '0;
		for (int r = TABLE_ROWS - 1; r >= 0; r--) begin
			if (FIELD_TABLE[r].group_id == grp && FIELD_TABLE[r].tag == tag) begin
				m.hit     = 1'b1;
				m.row     = ROW_W'(r);
				m.is_date = FIELD_TABLE[r].is_date;
			end
		end
		return m;
	endfunction

endpackage

@@ hdl/btfe_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER-TLV field extractor channels
// Valid/ready channels for record bytes in and matched field bytes out.
// ----------------------------------------------------------------------------
interface btfe_in_if;
	logic                           valid;
	logic                           ready;
	logic [btfe_pkg::BYTE_W-1:0]    data_byte;
	logic                           first_byte;
	logic [btfe_pkg::OFF_W-1:0]     record_length;
	logic [btfe_pkg::GRP_W-1:0]     group_id;

	modport source (output valid, data_byte, first_byte, record_length, group_id,
		input ready);
	modport sink (input valid, data_byte, first_byte, record_length, group_id,
		output ready);
endinterface

interface btfe_out_if;
	logic                           valid;
	logic                           ready;
	logic [btfe_pkg::ROW_W-1:0]     field_index;
	logic                           is_date;
	logic [btfe_pkg::BYTE_W-1:0]    value_byte;
	logic                           field_end;

	modport source (output valid, field_index, is_date, value_byte, field_end,
		input ready);
	modport sink (input valid, field_index, is_date, value_byte, field_end,
		output ready);
endinterface

@@ hdl/btfe_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module btfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/ber_tlv_field_extractor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER-TLV field extractor
// Walks a BER-TLV record byte by byte and emits the value bytes of known fields.
// ----------------------------------------------------------------------------
// Each accepted byte is parsed in the step state. When the byte closes inner
// frames, each inner frame closed adds a pass through the pop state, since
// the end of the frame around it is read back from the frame-end RAM (one
// read per cycle) before it can be compared; closing the outermost frame
// adds no pop. A matched field byte sits in an output register; a new byte
// is taken while no pop runs and that register is empty or being emptied.
// A byte taken with first_byte set restarts the record; lengths above 4096
// are clamped to 4096.
// ----------------------------------------------------------------------------
module ber_tlv_field_extractor (
	input  logic      clk,
	input  logic      arst_n,
	btfe_in_if.sink   byte_ch,
	btfe_out_if.source field_ch
);
	import btfe_pkg::*;

	typedef enum logic [2:0] {
		PH_TAG, PH_LEN, PH_LEN81, PH_LEN82_HI, PH_LEN82_LO, PH_EMIT, PH_SKIP, PH_DROP
	} phase_t;

	typedef enum logic {
		ST_STEP,
		ST_POP
	} ctrl_t;

	ctrl_t               st_q;
	phase_t              phase_q;
	logic                active_q;
	logic [OFF_W-1:0]    off_q;
	logic [TOP_W-1:0]    top_q;
	logic [OFF_W-1:0]    top_end_q;
	logic [BYTE_W-1:0]   tag_q;
	logic [LEN_W-1:0]    left_q;
	logic [GRP_W-1:0]    group_q;
	logic [ROW_W-1:0]    row_q;
	logic                date_q;

	logic                out_valid_q;
	logic [ROW_W-1:0]    out_index_q;
	logic                out_date_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                out_end_q;

	logic                acc;
	logic                first;
	logic [BYTE_W-1:0]   b;
	logic [OFF_W-1:0]    len_c;
	logic                act_c;
	logic [OFF_W-1:0]    off_c;
	logic [OFF_W-1:0]    end_c;
	logic [TOP_W-1:0]    top_c;
	logic [LEN_W-1:0]    left_c;
	logic [GRP_W-1:0]    grp_c;
	phase_t              phase_c;
	logic [OFF_W-1:0]    vstart;
	logic                hdr_go;
	logic [LEN_W-1:0]    hdr_len;
	logic [SUM_W-1:0]    hdr_sum;
	logic                is_ctx;
	logic                constructed;
	field_match_t        m;
	logic                emit;
	logic                emit_end;
	logic                push;
	logic                pop_go;

	phase_t              n_phase;
	logic                n_active;
	logic [OFF_W-1:0]    n_off;
	logic [TOP_W-1:0]    n_top;
	logic [OFF_W-1:0]    n_end;
	logic [BYTE_W-1:0]   n_tag;
	logic [LEN_W-1:0]    n_left;
	logic [ROW_W-1:0]    n_row;
	logic                n_date;

	logic                ram_we;
	logic [TOP_W-1:0]    ram_waddr;
	logic [OFF_W-1:0]    ram_wdata;
	logic [TOP_W-1:0]    ram_raddr;
	logic [OFF_W-1:0]    ram_rdata;

	assign byte_ch.ready = (st_q == ST_STEP) && (!out_valid_q || field_ch.ready);
	assign acc           = byte_ch.valid && byte_ch.ready;

	assign field_ch.valid       = out_valid_q;
	assign field_ch.field_index = out_index_q;
	assign field_ch.is_date     = out_date_q;
	assign field_ch.value_byte  = out_byte_q;
	assign field_ch.field_end   = out_end_q;

	// one byte step; top_end_q caches frame_ends[top] so no read is needed here
	always_comb begin
		first   = byte_ch.first_byte;
		b       = byte_ch.data_byte;
		len_c   = (byte_ch.record_length > OFF_W'(RECORD_BYTES)) ?
			OFF_W'(RECORD_BYTES) : byte_ch.record_length;
		act_c   = first ? (len_c != '0) : active_q;
		off_c   = first ? '0 : off_q;
		end_c   = first ? len_c : top_end_q;
		top_c   = first ? '0 : top_q;
		left_c  = first ? '0 : left_q;
		grp_c   = first ? byte_ch.group_id : group_q;
		phase_c = first ? PH_TAG : phase_q;

		vstart      = off_c + OFF_W'(1);
		constructed = |(tag_q & TAG_CONSTRUCTED);
		is_ctx      = ((tag_q & CLASS_MASK) == CLASS_CTX) && !constructed;
		m           = lookup_field(grp_c, tag_q);

		hdr_go   = 1'b0;
		hdr_len  = '0;
		emit     = 1'b0;
		emit_end = 1'b0;
		push     = 1'b0;
		pop_go   = 1'b0;

		n_phase  = phase_c;
		n_active = act_c;
		n_off    = off_c;
		n_top    = top_c;
		n_end    = end_c;
		n_tag    = tag_q;
		n_left   = left_c;
		n_row    = row_q;
		n_date   = date_q;

		if (act_c) begin
			unique case (phase_c)
				PH_TAG: begin
					n_tag   = b;
					n_phase = PH_LEN;
				end
				PH_LEN: begin
					if (!b[BYTE_W-1]) begin
						hdr_go  = 1'b1;
						hdr_len = LEN_W'(b);
					end else if (b == LEN_LONG1 && vstart < end_c) begin
						n_phase = PH_LEN81;
					end else if (b == LEN_LONG2 &&
							({1'b0, off_c} + (OFF_W+1)'(2)) < {1'b0, end_c}) begin
						n_phase = PH_LEN82_HI;
					end else begin
						n_phase = PH_DROP;
					end
				end
				PH_LEN81: begin
					hdr_go  = 1'b1;
					hdr_len = LEN_W'(b);
				end
				PH_LEN82_HI: begin
					n_left  = LEN_W'(b);
					n_phase = PH_LEN82_LO;
				end
				PH_LEN82_LO: begin
					hdr_go  = 1'b1;
					hdr_len = {left_c[BYTE_W-1:0], b};
				end
				PH_EMIT: begin
					emit     = 1'b1;
					emit_end = (left_c == LEN_W'(1));
					if (left_c != '0) begin
						n_left = left_c - LEN_W'(1);
					end
					if (n_left == '0) begin
						n_phase = PH_TAG;
					end
				end
				PH_SKIP: begin
					if (left_c != '0) begin
						n_left = left_c - LEN_W'(1);
					end
					if (n_left == '0) begin
						n_phase = PH_TAG;
					end
				end
				PH_DROP: begin
					n_phase = PH_DROP;
				end
				default: begin
					n_phase = PH_DROP;
				end
			endcase
		end

		hdr_sum = SUM_W'(vstart) + SUM_W'(hdr_len);

		if (act_c && hdr_go) begin
			if (hdr_sum > SUM_W'(end_c)) begin
				n_phase = PH_DROP;
			end else begin
				n_phase = PH_TAG;
				if (hdr_len != '0) begin
					if (is_ctx) begin
						n_left  = hdr_len;
						n_row   = m.row;
						n_date  = m.is_date;
						n_phase = m.hit ? PH_EMIT : PH_SKIP;
					end else if (constructed && top_c < TOP_W'(NEST_LIMIT)) begin
						push  = 1'b1;
						n_top = top_c + TOP_W'(1);
						n_end = hdr_sum[OFF_W-1:0];
					end else begin
						n_left  = hdr_len;
						n_phase = PH_SKIP;
					end
				end
			end
		end

		// close the frame that ends here; closes of the frames around it continue in ST_POP
		if (act_c) begin
			n_off = vstart;
			if (n_off >= n_end) begin
				n_phase = PH_TAG;
				n_left  = '0;
				if (n_top == '0) begin
					n_active = 1'b0;
				end else begin
					n_top  = n_top - TOP_W'(1);
					pop_go = 1'b1;
				end
			end
		end
	end

	// writes go to top+1 or to entry 0 and reads to the new top or below; they
	// meet on one entry only in a step that pops nothing, when rdata goes unused
	assign ram_we    = acc && (first || push);
	assign ram_waddr = first ? '0 : top_c + TOP_W'(1);
	assign ram_wdata = first ? len_c : hdr_sum[OFF_W-1:0];
	assign ram_raddr = (st_q == ST_POP) ? top_q - TOP_W'(1) : n_top;

	btfe_ram #(
		.WIDTH (OFF_W),
		.DEPTH (FRAME_DEPTH)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_STEP;
			phase_q     <= PH_TAG;
			active_q    <= 1'b0;
			off_q       <= '0;
			top_q       <= '0;
			top_end_q   <= '0;
			tag_q       <= '0;
			left_q      <= '0;
			group_q     <= '0;
			row_q       <= '0;
			date_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_index_q <= '0;
			out_date_q  <= 1'b0;
			out_byte_q  <= '0;
			out_end_q   <= 1'b0;
		end else begin
			if (acc && emit) begin
				out_valid_q <= 1'b1;
				out_index_q <= row_q;
				out_date_q  <= date_q;
				out_byte_q  <= b;
				out_end_q   <= emit_end;
			end else if (field_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (st_q)
				ST_STEP: begin
					if (acc) begin
						phase_q   <= n_phase;
						active_q  <= n_active;
						off_q     <= n_off;
						top_q     <= n_top;
						top_end_q <= n_end;
						tag_q     <= n_tag;
						left_q    <= n_left;
						group_q   <= grp_c;
						row_q     <= n_row;
						date_q    <= n_date;
						if (pop_go) begin
							st_q <= ST_POP;
						end
					end
				end
				ST_POP: begin
					// parent frame end has arrived: adopt it or pop once more
					top_end_q <= ram_rdata;
					if (off_q >= ram_rdata) begin
						if (top_q == '0) begin
							active_q <= 1'b0;
							st_q     <= ST_STEP;
						end else begin
							top_q <= top_q - TOP_W'(1);
						end
					end else begin
						st_q <= ST_STEP;
					end
				end
				default: begin
					st_q <= ST_STEP;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= TOP_W'(NEST_LIMIT))
		else $error("frame stack deeper than the nesting limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (phase_q == PH_TAG && left_q == '0))
		else $error("parser state left over with no active record");

	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_POP) |-> active_q)
		else $error("frame pop running with no active record");

	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EMIT) |-> (left_q != '0))
		else $error("emitting a field with no value bytes left");

	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && pop_go) |=> (st_q == ST_POP && !byte_ch.ready))
		else $error("next item taken before nested frames were closed");

endmodule

@@ tb/sv/btfe_field_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER-TLV field extractor checker
// Follows the TLV walk of every byte taken by the extractor, builds the field
// bytes it must produce and compares them with what leaves the output channel.
// ----------------------------------------------------------------------------
module btfe_field_checker (
	input  logic clk,
	input  logic arst_n,
	btfe_in_if   byte_ch,
	btfe_out_if  field_ch,
	output int   fail_count,
	output int   due_count
);
	import btfe_pkg::*;

	typedef enum logic [2:0] {
		EXP_TAG,
		EXP_LEN,
		EXP_LEN1,
		EXP_LEN2_HI,
		EXP_LEN2_LO,
		EMIT_VALUE,
		SKIP_VALUE,
		DROP_FRAME
	} tlv_phase_e;

	typedef struct packed {
		logic [ROW_W-1:0]  idx;
		logic              date;
		logic [BYTE_W-1:0] val;
		logic              last;
	} field_byte_t;

	localparam logic [4:0] NO_ROW = 5'd31;

	logic [OFF_W-1:0]  rec_pos;
	logic [OFF_W-1:0]  frame_end [FRAME_DEPTH];
	logic [4:0]        depth;
	logic              in_record;
	tlv_phase_e        phase;
	logic [BYTE_W-1:0] cur_tag;
	logic [LEN_W-1:0]  value_left;
	logic [GRP_W-1:0]  rec_group;
	logic [4:0]        cur_row;
	field_byte_t       field_bytes_due [$];
	int                mismatches;

	function automatic logic [4:0] table_row(input logic [GRP_W-1:0] grp,
			input logic [BYTE_W-1:0] tag);
		case ({grp, tag})
			{16'h0101, 8'h80}: return 5'd0;
			{16'h0101, 8'h81}: return 5'd1;
			{16'h0101, 8'h82}: return 5'd2;
			{16'h0101, 8'h83}: return 5'd3;
			{16'h0101, 8'h84}: return 5'd4;
			{16'h0101, 8'h85}: return 5'd5;
			{16'h0102, 8'h81}: return 5'd6;
			{16'h0104, 8'h80}: return 5'd7;
			{16'h0104, 8'h81}: return 5'd8;
			{16'h0104, 8'h82}: return 5'd9;
			{16'h0104, 8'h83}: return 5'd10;
			{16'h0106, 8'h80}: return 5'd11;
			{16'h0107, 8'h81}: return 5'd12;
			{16'h0107, 8'h82}: return 5'd13;
			{16'h0109, 8'h80}: return 5'd14;
			default: return NO_ROW;
		endcase
	endfunction

	function automatic logic row_date(input logic [4:0] row);
		return row inside {5'd3, 5'd8, 5'd9, 5'd12, 5'd13};
	endfunction

	function automatic string show(input field_byte_t f);
		return $sformatf("idx=%0d date=%0b val=%02h end=%0b", f.idx, f.date, f.val, f.last);
	endfunction

	// header complete: tlen value bytes start at offset vstart
	task automatic open_value(input int tlen, input int vstart);
		int   lim;
		logic constructed;
		logic ctx;
		lim = frame_end[depth];
		constructed = (cur_tag & TAG_CONSTRUCTED) != 0;
		ctx = ((cur_tag & CLASS_MASK) == CLASS_CTX) && !constructed;
		if (vstart + tlen > lim) begin
			phase = DROP_FRAME;
			return;
		end
		phase = EXP_TAG;
		if (tlen == 0)
			return;
		if (ctx) begin
			cur_row = table_row(rec_group, cur_tag);
			value_left = LEN_W'(tlen);
			phase = (cur_row != NO_ROW) ? EMIT_VALUE : SKIP_VALUE;
		end else if (constructed && depth < NEST_LIMIT) begin
			depth++;
			frame_end[depth] = OFF_W'(vstart + tlen);
		end else begin
			value_left = LEN_W'(tlen);
			phase = SKIP_VALUE;
		end
	endtask

	task automatic walk_record_byte(input logic [BYTE_W-1:0] b, input logic first,
			input logic [OFF_W-1:0] rlen, input logic [GRP_W-1:0] grp);
		int          len;
		int          pos;
		int          lim;
		field_byte_t fbyte;
		if (first) begin
			len = (rlen > RECORD_BYTES) ? RECORD_BYTES : int'(rlen);
			rec_pos = '0;
			depth = '0;
			frame_end[0] = OFF_W'(len);
			rec_group = grp;
			phase = EXP_TAG;
			value_left = '0;
			cur_row = NO_ROW;
			in_record = (len != 0);
		end
		if (!in_record)
			return;
		pos = rec_pos;
		lim = frame_end[depth];
		case (phase)
			EXP_TAG: begin
				cur_tag = b;
				phase = EXP_LEN;
			end
			EXP_LEN: begin
				if (!b[7])
					open_value(b, pos + 1);
				else if (b == LEN_LONG1 && pos + 1 < lim)
					phase = EXP_LEN1;
				else if (b == LEN_LONG2 && pos + 2 < lim)
					phase = EXP_LEN2_HI;
				else
					phase = DROP_FRAME;
			end
			EXP_LEN1: open_value(b, pos + 1);
			EXP_LEN2_HI: begin
				value_left = LEN_W'(b);
				phase = EXP_LEN2_LO;
			end
			EXP_LEN2_LO: open_value({value_left[7:0], b}, pos + 1);
			EMIT_VALUE: begin
				fbyte.idx  = cur_row[ROW_W-1:0];
				fbyte.date = row_date(cur_row);
				fbyte.val  = b;
				fbyte.last = (value_left == 1);
				field_bytes_due.push_back(fbyte);
				if (value_left != 0)
					value_left--;
				if (value_left == 0)
					phase = EXP_TAG;
			end
			SKIP_VALUE: begin
				if (value_left != 0)
					value_left--;
				if (value_left == 0)
					phase = EXP_TAG;
			end
			default: ;
		endcase
		rec_pos = OFF_W'(pos + 1);
		// close every frame that ends on this byte
		while (in_record && rec_pos >= frame_end[depth]) begin
			phase = EXP_TAG;
			value_left = '0;
			if (depth == 0)
				in_record = 1'b0;
			else
				depth--;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		field_byte_t got;
		field_byte_t want;
		if (!arst_n) begin
			rec_pos = '0;
			depth = '0;
			in_record = 1'b0;
			phase = EXP_TAG;
			cur_tag = '0;
			value_left = '0;
			rec_group = '0;
			cur_row = NO_ROW;
			field_bytes_due.delete();
			mismatches = 0;
			fail_count <= 0;
			due_count <= 0;
		end else begin
			if (byte_ch.valid && byte_ch.ready)
				walk_record_byte(byte_ch.data_byte, byte_ch.first_byte,
					byte_ch.record_length, byte_ch.group_id);
			if (field_ch.valid && field_ch.ready) begin
				got = {field_ch.field_index, field_ch.is_date, field_ch.value_byte,
					field_ch.field_end};
				if (field_bytes_due.size() == 0) begin
					mismatches++;
					$display("%0t: field byte with none due: expected nothing, got %s",
						$time, show(got));
				end else begin
					want = field_bytes_due.pop_front();
					if (got.idx !== want.idx || got.date !== want.date ||
							got.val !== want.val || got.last !== want.last) begin
						mismatches++;
						$display("%0t: field byte mismatch: expected %s, got %s",
							$time, show(want), show(got));
					end
				end
			end
			fail_count <= mismatches;
			due_count <= field_bytes_due.size();
		end
	end

endmodule

@@ tb/sv/tb_ber_tlv_field_extractor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER-TLV field extractor testbench
// Feeds short directed records, then random nested TLV records mixed with
// noise, broken headers and abandoned records, with random gaps on both
// channels; the checker beside the block judges every field byte.
// ----------------------------------------------------------------------------
module tb_ber_tlv_field_extractor;
	import btfe_pkg::*;

	localparam int ITEM_TARGET = 1350;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 64;
	localparam int HOLD_FROM   = 600;
	localparam int HOLD_CYCLES = 400;
	localparam int CALM_FROM   = 1500;
	localparam int CALM_CYCLES = 800;

	localparam logic [GRP_W-1:0] KNOWN_GROUPS [6] = '{16'h0101, 16'h0102, 16'h0104,
		16'h0106, 16'h0107, 16'h0109};

	logic clk;
	logic arst_n;
	int   fails;
	int   due;
	int   gap_pct;
	int   bytes_sent;
	int   cycles;

	logic [BYTE_W-1:0] tlv_body [$];
	int                elem_start [$];

	btfe_in_if  byte_ch ();
	btfe_out_if field_ch ();

	ber_tlv_field_extractor DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.field_ch (field_ch)
	);

	btfe_field_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_ch    (byte_ch),
		.field_ch   (field_ch),
		.fail_count (fails),
		.due_count  (due)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// receiver: random stalls, one long hold-off and one stretch with none
	initial begin
		int rx_cycle;
		rx_cycle = 0;
		field_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_FROM + HOLD_CYCLES)
				field_ch.ready <= 1'b0;
			else if (rx_cycle >= CALM_FROM && rx_cycle < CALM_FROM + CALM_CYCLES)
				field_ch.ready <= 1'b1;
			else
				field_ch.ready <= ($urandom_range(99) >= 20);
		end
	end

	task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic first,
			input logic [OFF_W-1:0] rlen, input logic [GRP_W-1:0] grp);
		while ($urandom_range(99) < gap_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.first_byte <= first;
		// length and group only count on a first byte: scramble them elsewhere
		byte_ch.record_length <= first ? rlen : OFF_W'($urandom);
		byte_ch.group_id <= first ? grp : GRP_W'($urandom);
		do @(posedge clk); while (!byte_ch.ready);
		bytes_sent++;
	endtask

	task automatic wait_fields_out();
		byte_ch.valid <= 1'b0;
		do @(posedge clk); while (due != 0);
	endtask

	task automatic send_body(input logic [GRP_W-1:0] grp, input int rlen, input int count);
		for (int i = 0; i < count; i++)
			offer_byte(tlv_body[i], i == 0, OFF_W'(rlen), grp);
	endtask

	task automatic put_header(input int at, input logic [BYTE_W-1:0] tag, input int len);
		logic [BYTE_W-1:0] hdr [$];
		hdr.push_back(tag);
		if (len < 128 && $urandom_range(3) != 0) begin
			hdr.push_back(BYTE_W'(len));
		end else if (len < 256 && $urandom_range(1) == 0) begin
			hdr.push_back(LEN_LONG1);
			hdr.push_back(BYTE_W'(len));
		end else begin
			hdr.push_back(LEN_LONG2);
			hdr.push_back(BYTE_W'(len >> 8));
			hdr.push_back(BYTE_W'(len));
		end
		foreach (hdr[i])
			tlv_body.insert(at + i, hdr[i]);
	endtask

	task automatic add_primitive();
		int                pick;
		int                len;
		int                at;
		logic [BYTE_W-1:0] tag;
		pick = $urandom_range(99);
		if (pick < 60)
			tag = CLASS_CTX | BYTE_W'($urandom_range(5));
		else if (pick < 80)
			tag = {2'b10, 1'b0, 5'($urandom)};
		else
			tag = BYTE_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 70)
			len = $urandom_range(4);
		else if (pick < 99)
			len = $urandom_range(5, 12);
		else
			len = $urandom_range(128, 300);
		at = tlv_body.size();
		elem_start.push_back(at);
		put_header(at, tag, len);
		repeat (len) tlv_body.push_back(BYTE_W'($urandom));
	endtask

	// wrap the top-level elements from index keep onwards in one constructed element
	task automatic wrap_elements(input int keep);
		int at;
		at = elem_start[keep];
		put_header(at, TAG_CONSTRUCTED | BYTE_W'($urandom), tlv_body.size() - at);
		while (elem_start.size() > keep + 1)
			void'(elem_start.pop_back());
	endtask

	task automatic build_record(input bit deep);
		tlv_body.delete();
		elem_start.delete();
		add_primitive();
		repeat ($urandom_range(5)) begin
			if ($urandom_range(2) == 0)
				wrap_elements($urandom_range(elem_start.size() - 1));
			else
				add_primitive();
		end
		// nest up to or past the limit so the innermost frames may get skipped whole
		if (deep)
			repeat ($urandom_range(29, 33)) wrap_elements(0);
	endtask

	task automatic send_built_record();
		int               pick;
		int               rlen;
		int               count;
		logic [GRP_W-1:0] grp;
		grp = ($urandom_range(99) < 85) ? KNOWN_GROUPS[$urandom_range(5)] : GRP_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 8)
			repeat ($urandom_range(1, 4)) tlv_body.push_back(BYTE_W'($urandom));
		rlen = tlv_body.size();
		count = rlen;
		if (pick >= 8 && pick < 14)
			rlen = rlen - $urandom_range(1, rlen);
		else if (pick >= 14 && pick < 19)
			count = $urandom_range(1, count);
		send_body(grp, rlen, count);
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 3)) offer_byte(BYTE_W'($urandom), 1'b0, '0, '0);
	endtask

	task automatic send_clamped_record();
		int len;
		len = $urandom_range(4090, 4094);
		tlv_body = '{CLASS_CTX | BYTE_W'($urandom_range(5)), LEN_LONG2, BYTE_W'(len >> 8),
			BYTE_W'(len)};
		repeat ($urandom_range(1, 4)) tlv_body.push_back(BYTE_W'($urandom));
		send_body(KNOWN_GROUPS[$urandom_range(5)], $urandom_range(4097, 8191),
			tlv_body.size());
	endtask

	initial begin
		int pick;
		int rec_no;
		arst_n <= 1'b0;
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		byte_ch.first_byte <= 1'b0;
		byte_ch.record_length <= '0;
		byte_ch.group_id <= '0;
		gap_pct = 20;
		bytes_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty record, then a byte with no record open
		tlv_body = '{8'h00};
		send_body(16'hFFFF, 0, 1);
		offer_byte(8'hFF, 1'b0, '0, '0);
		// date field, short form, byte extremes
		tlv_body = '{8'h83, 8'h03, 8'h00, 8'hFF, 8'h5A};
		send_body(16'h0101, 5, tlv_body.size());
		// 0x81 length form
		tlv_body = '{8'h82, LEN_LONG1, 8'h02, 8'hA5, 8'h3C};
		send_body(16'h0107, 5, tlv_body.size());
		// oversized record length, clamped; abandoned by the next record
		tlv_body = '{8'h83, LEN_LONG2, 8'h0F, 8'hFC, 8'h11, 8'h22};
		send_body(16'h0104, 8191, tlv_body.size());
		// three frames closing on the same byte
		tlv_body = '{8'h61, 8'h05, 8'hA0, 8'h03, 8'h80, 8'h01, 8'hEE};
		send_body(16'h0106, 7, tlv_body.size());
		// header cut by the frame end, then an unknown length form
		tlv_body = '{8'h80, LEN_LONG2, 8'h00};
		send_body(16'h0109, 3, tlv_body.size());
		tlv_body = '{8'h81, 8'hFF, 8'h00};
		send_body(16'h0102, 3, tlv_body.size());
		wait_fields_out();

		rec_no = 0;
		while (bytes_sent < ITEM_TARGET) begin
			rec_no++;
			gap_pct = (rec_no >= 20 && rec_no < 30) ? 0 : 20;
			pick = $urandom_range(99);
			if (pick < 78) begin
				build_record(rec_no % 30 == 5 || $urandom_range(24) == 0);
				send_built_record();
			end else if (pick < 90) begin
				tlv_body.delete();
				repeat ($urandom_range(1, 10)) tlv_body.push_back(BYTE_W'($urandom));
				send_body(GRP_W'($urandom), $urandom_range(8191), tlv_body.size());
			end else if (pick < 95) begin
				offer_byte(BYTE_W'($urandom), 1'b1, '0, GRP_W'($urandom));
			end else begin
				send_clamped_record();
			end
			if (rec_no % 15 == 0)
				wait_fields_out();
		end

		wait_fields_out();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && due == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
